// ===== hdl/dmd_pkg.sv =====
// ============================================================================
// dmd_pkg: shared types, constants and the Morse lookup table
// Holds the dibit codes, the queue entry layout and the table search used
// by the front end of the dibit Morse decoder.
// ============================================================================
package dmd_pkg;

    // Dibit codes, most significant dibit of a byte first
    localparam logic [1:0] DIBIT_CHAR_END = 2'b00;
    localparam logic [1:0] DIBIT_DASH     = 2'b01;
    localparam logic [1:0] DIBIT_DOT      = 2'b10;
    localparam logic [1:0] DIBIT_WORD_END = 2'b11;

    // Field widths and limits
    localparam int CODE_W      = 14;
    localparam int COUNT_W     = 4;
    localparam int ASCII_W     = 7;
    localparam int SLOTS       = 4;
    localparam int MAX_RESULTS = 2 * SLOTS;
    localparam int RESULT_W    = $clog2(MAX_RESULTS + 1);
    localparam int INDEX_W     = $clog2(MAX_RESULTS);

    localparam logic [COUNT_W-1:0] MAX_SYMBOLS = 4'd7;
    localparam logic [COUNT_W-1:0] TOO_LONG    = 4'd8;
    localparam logic [ASCII_W-1:0] SPACE_CHAR  = 7'h20;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Table size and search depth
    localparam int TABLE_ENTRIES = 46;
    localparam int TABLE_SIZE    = 64;
    localparam int SEARCH_DEPTH  = (TABLE_ENTRIES < TABLE_SIZE) ? TABLE_ENTRIES : TABLE_SIZE;

    // One character or word end found in a byte
    typedef struct packed {
        logic              is_end;
        logic              is_word;
        logic              code_ok;
        logic [CODE_W-1:0] code;
    } slot_t;

    // All results caused by one byte, in output order
    typedef struct packed {
        logic [RESULT_W-1:0]                  count;
        logic [MAX_RESULTS-1:0][ASCII_W-1:0] chars;
    } run_t;

    // Result of a table search
    typedef struct packed {
        logic               hit;
        logic [ASCII_W-1:0] ascii;
    } lut_t;

    // Symbol codes, two bits per symbol, last symbol in the low bits
    localparam logic [CODE_W-1:0] MORSE_CODE [TABLE_SIZE] = '{
        14'h009, 14'h06A, 14'h066, 14'h01A, 14'h002, 14'h0A6, 14'h016, 14'h0AA,
        14'h00A, 14'h095, 14'h019, 14'h09A, 14'h005, 14'h006, 14'h015, 14'h096,
        14'h059, 14'h026, 14'h02A, 14'h001, 14'h029, 14'h0A9, 14'h025, 14'h069,
        14'h065, 14'h05A, 14'h155, 14'h255, 14'h295, 14'h2A5, 14'h2A9, 14'h2AA,
        14'h1AA, 14'h16A, 14'h15A, 14'h156, 14'h956, 14'h966, 14'h56A, 14'h5A5,
        14'h2A69, 14'h1A9, 14'h665, 14'h999, 14'hA5A, 14'h9A6, 14'h000, 14'h000,
        14'h000, 14'h000, 14'h000, 14'h000, 14'h000, 14'h000, 14'h000, 14'h000,
        14'h000, 14'h000, 14'h000, 14'h000, 14'h000, 14'h000, 14'h000, 14'h000
    };

    // ASCII character for each table entry
    localparam logic [ASCII_W-1:0] MORSE_ASCII [TABLE_SIZE] = '{
        7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48,
        7'h49, 7'h4A, 7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F, 7'h50,
        7'h51, 7'h52, 7'h53, 7'h54, 7'h55, 7'h56, 7'h57, 7'h58,
        7'h59, 7'h5A, 7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35,
        7'h36, 7'h37, 7'h38, 7'h39, 7'h27, 7'h40, 7'h3A, 7'h2C,
        7'h24, 7'h3D, 7'h21, 7'h2E, 7'h3F, 7'h22, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    // Parallel compare against every searched entry; an all-zero entry
    // never matches, and the first matching entry wins.
    function automatic lut_t morse_lookup(input logic [CODE_W-1:0] code);
        lut_t res;
        res.hit   = 1'b0;
        res.ascii = '0;
        for (int i = SEARCH_DEPTH - 1; i >= 0; i--)
        begin
            if ((MORSE_CODE[i] != '0) && (MORSE_CODE[i] == code))
            begin
                res.hit   = 1'b1;
                res.ascii = MORSE_ASCII[i];
            end
        end
        return res;
    endfunction

endpackage

// ===== hdl/dibit_morse_decoder.sv =====
// ============================================================================
// dibit_morse_decoder: Morse decoder fed with dibit-coded bytes
// Front end parses bytes and looks up characters, a four-entry queue holds
// the results of each byte, and the back end sends them one per beat.
// ============================================================================
//
//  Channel  Direction  tdata                         tuser  tlast
//  s_*      in         [7:0] code_byte               -      -
//  m_*      out        [6:0] char_code, [7] zero     -      last_of_run
//
// A byte is accepted every cycle while the queue has room; the output sends
// one character per cycle while m_tready is high. The first character of a
// byte passes the parse stage register, the queue, the run register and the
// output register. Reset clears the pending code, the queue and the output
// valid flag; no clearing pass is needed. Either side may stall freely: the
// queue absorbs up to four byte runs.
//
module dibit_morse_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] code_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [6:0] char_code, [7] zero
    output logic       m_tlast      // last_of_run
);

    logic          push;
    dmd_pkg::run_t push_data;
    logic          fifo_full;
    logic          pop;
    logic          not_empty;
    dmd_pkg::run_t pop_data;

    // Parser and lookup
    dmd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (push),
        .push_data (push_data),
        .fifo_full (fifo_full)
    );

    // Run queue
    dmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_data  (pop_data)
    );

    // Output serializer
    dmd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .pop_data  (pop_data),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== hdl/dmd_front.sv =====
// ============================================================================
// dmd_front: byte parser and character lookup
// Splits each accepted byte into dibits, tracks the pending symbol code,
// registers the character and word ends, then looks them up and packs the
// results of the byte into one queue entry.
// ============================================================================
module dmd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,     // [7:0] code_byte
    output logic              push,
    output dmd_pkg::run_t     push_data,
    input  logic              fifo_full
);

    logic [dmd_pkg::CODE_W-1:0]  pend_reg, pend_next;
    logic [dmd_pkg::COUNT_W-1:0] cnt_reg, cnt_next;
    logic                        stage_valid_reg;
    dmd_pkg::slot_t [dmd_pkg::SLOTS-1:0] slots_reg, slots_next;
    logic                        accept;
    logic                        stage_free;
    dmd_pkg::run_t               run;

    // Walk the four dibits of the incoming byte, most significant first
    always_comb
    begin
        logic [1:0] dib;
        pend_next  = pend_reg;
        cnt_next   = cnt_reg;
        slots_next = '0;
        for (int k = 0; k < dmd_pkg::SLOTS; k++)
        begin
            dib = s_tdata[2 * (dmd_pkg::SLOTS - 1 - k) +: 2];
            if ((dib == dmd_pkg::DIBIT_DOT) || (dib == dmd_pkg::DIBIT_DASH))
            begin
                if (cnt_next < dmd_pkg::MAX_SYMBOLS)
                begin
                    pend_next = {pend_next[dmd_pkg::CODE_W-3:0], dib};
                    cnt_next  = cnt_next + 1'b1;
                end
                else
                begin
                    cnt_next = dmd_pkg::TOO_LONG;
                end
            end
            else
            begin
                slots_next[k].is_end  = 1'b1;
                slots_next[k].is_word = (dib == dmd_pkg::DIBIT_WORD_END);
                slots_next[k].code_ok = (cnt_next != '0) &&
                                        (cnt_next <= dmd_pkg::MAX_SYMBOLS);
                slots_next[k].code    = pend_next;
                pend_next = '0;
                cnt_next  = '0;
            end
        end
    end

    // Look up each end and pack the results in order
    always_comb
    begin
        dmd_pkg::lut_t                 lut;
        logic [dmd_pkg::RESULT_W-1:0]  n;
        run = '0;
        n   = '0;
        for (int k = 0; k < dmd_pkg::SLOTS; k++)
        begin
            lut = dmd_pkg::morse_lookup(slots_reg[k].code);
            if (slots_reg[k].is_end && slots_reg[k].is_word)
            begin
                run.chars[n[dmd_pkg::INDEX_W-1:0]] = dmd_pkg::SPACE_CHAR;
                n = n + 1'b1;
            end
            if (slots_reg[k].is_end && slots_reg[k].code_ok && lut.hit)
            begin
                run.chars[n[dmd_pkg::INDEX_W-1:0]] = lut.ascii;
                n = n + 1'b1;
            end
        end
        run.count = n;
    end

    // A byte with no results simply leaves the stage
    assign stage_free = !stage_valid_reg || (run.count == '0) || !fifo_full;
    assign s_tready   = stage_free;
    assign accept     = s_tvalid && stage_free;
    assign push       = stage_valid_reg && (run.count != '0) && !fifo_full;
    assign push_data  = run;

    // Control state and pending code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg        <= '0;
            cnt_reg         <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pend_reg <= pend_next;
                cnt_reg  <= cnt_next;
            end
            if (stage_free)
            begin
                stage_valid_reg <= s_tvalid;
            end
        end
    end

    // Parse stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slots_reg <= slots_next;
        end
    end

endmodule

// ===== hdl/dmd_fifo.sv =====
// ============================================================================
// dmd_fifo: short queue of byte runs
// Show-ahead queue that decouples the parser from the output serializer.
// ============================================================================
module dmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dmd_pkg::run_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output dmd_pkg::run_t pop_data
);

    dmd_pkg::run_t                  mem_reg [dmd_pkg::FIFO_DEPTH];
    logic [dmd_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [dmd_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [dmd_pkg::FIFO_CNT_W-1:0] count_reg;

    assign full      = (count_reg == dmd_pkg::FIFO_CNT_W'(dmd_pkg::FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/dmd_back.sv =====
// ============================================================================
// dmd_back: output serializer
// Takes one byte run from the queue and sends its characters one beat at a
// time through an output register, marking the final one with tlast.
// ============================================================================
module dmd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          not_empty,
    input  dmd_pkg::run_t pop_data,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,     // [6:0] char_code, [7] zero
    output logic          m_tlast      // last_of_run
);

    dmd_pkg::run_t                  run_reg;
    logic                           busy_reg;
    logic [dmd_pkg::INDEX_W-1:0]    idx_reg;
    logic                           out_valid_reg;
    logic [dmd_pkg::ASCII_W-1:0]    out_char_reg;
    logic                           out_last_reg;
    logic                           advance;
    logic                           is_last;

    assign advance = !out_valid_reg || m_tready;
    assign is_last = ({1'b0, idx_reg} + 1'b1) == run_reg.count;
    assign pop     = not_empty && (!busy_reg || (advance && is_last));

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tlast  = out_last_reg;

    // Run tracking and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= busy_reg;
                if (busy_reg)
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (is_last)
                    begin
                        busy_reg <= 1'b0;
                    end
                end
            end
            if (pop)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
        end
    end

    // Run payload and output beat
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            run_reg <= pop_data;
        end
        if (advance && busy_reg)
        begin
            out_char_reg <= run_reg.chars[idx_reg];
            out_last_reg <= is_last;
        end
    end

endmodule
